@@ rtl/assert_macros.svh @@
// Assertion macros shared by the volume convolution RTL.
// Each macro expands to a labeled concurrent assertion, or to nothing when ASSERT_OFF is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ rtl/vc3_pkg.sv @@
// Shared constants, types and helper functions for the 3x3x3 volume convolution.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
package vc3_pkg;

  localparam int DIM_MAX       = 16;
  localparam int KERNEL_RADIUS = 1;
  localparam int KSIDE         = 2 * KERNEL_RADIUS + 1;
  localparam int KTAPS         = KSIDE * KSIDE * KSIDE;
  localparam int VOXELS        = DIM_MAX * DIM_MAX * DIM_MAX;

  // Field widths fixed by the interface.
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 4;
  localparam int TAP_W    = 5;
  localparam int SIZE_W   = 5;
  localparam int SAMPLE_W = 16;
  localparam int RESULT_W = 36;
  localparam int PROD_W   = 2 * SAMPLE_W;

  // Derived internal widths.
  localparam int CW     = $clog2(DIM_MAX);
  localparam int VOX_AW = 3 * CW;
  localparam int KT_W   = $clog2(KTAPS);
  localparam int KOFF_W = $clog2(KSIDE);
  localparam int NB_W   = SIZE_W + 1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    REG_SIZE_X    = 2'd0,
    REG_SIZE_Y    = 2'd1,
    REG_SIZE_Z    = 2'd2,
    REG_PAD_LEVEL = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } vc3_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear_acc;
    logic issue;
    logic wr_kernel;
    logic wr_voxel;
    logic finish;
    logic fin_status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_code_t cmd;
    logic      coord_err;
    logic      tap_err;
    logic      last_tap;
    logic      busy;
    logic      out_free;
  } dp_status_t;

  // A size register above DIM_MAX acts as DIM_MAX.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] lim;
    lim = SIZE_W'(DIM_MAX);
    return (s > lim) ? lim : s;
  endfunction

endpackage

@@ rtl/vc3_ram.sv @@
// Generic single-port RAM with registered read data.
// Holds the voxel volume; depends on nothing.
`timescale 1ns / 1ps
module vc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/vc3_ctrl.sv @@
// Controller state machine for the volume convolution: accepts items and sequences
// the datapath through decode, tap issue, pipeline drain and result hand-off. Uses vc3_pkg.
`timescale 1ns / 1ps
module vc3_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  vc3_pkg::dp_status_t st,
  output vc3_pkg::ctrl_cmd_t  cmd
);
  import vc3_pkg::*;

  vc3_state_t state, state_next;
  logic       err, err_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      err   <= err_next;
    end
  end

  always_comb begin
    state_next = state;
    err_next   = err;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        // The accumulator is cleared for every item so that non-compute items report zero.
        cmd.clear_acc = 1'b1;
        err_next      = 1'b0;
        state_next    = ST_FINISH;
        case (st.cmd)
          CMD_LOAD: begin
            if (st.tap_err) begin
              err_next = 1'b1;
            end else begin
              cmd.wr_kernel = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (st.coord_err) begin
              err_next = 1'b1;
            end else begin
              cmd.wr_voxel = 1'b1;
            end
          end
          CMD_COMPUTE: begin
            if (st.coord_err) begin
              err_next = 1'b1;
            end else begin
              state_next = ST_RUN;
            end
          end
          default: begin
            err_next = 1'b1;
          end
        endcase
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (st.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!st.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = err;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/vc3_datapath.sv @@
// Datapath for the volume convolution: item registers, kernel store, voxel RAM,
// neighbor addressing, multiply-accumulate pipeline and result register. Uses vc3_pkg, vc3_ram.
`timescale 1ns / 1ps
module vc3_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  vc3_pkg::ctrl_cmd_t                   cmd_in,
  output vc3_pkg::dp_status_t                  st,
  input  logic [vc3_pkg::CMD_W-1:0]            cmd,
  input  logic [vc3_pkg::COORD_W-1:0]          coord_x,
  input  logic [vc3_pkg::COORD_W-1:0]          coord_y,
  input  logic [vc3_pkg::COORD_W-1:0]          coord_z,
  input  logic [vc3_pkg::TAP_W-1:0]            tap_index,
  input  logic signed [vc3_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic [vc3_pkg::SIZE_W-1:0]           size_x,
  input  logic [vc3_pkg::SIZE_W-1:0]           size_y,
  input  logic [vc3_pkg::SIZE_W-1:0]           size_z,
  input  logic signed [vc3_pkg::SAMPLE_W-1:0]  pad_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [vc3_pkg::RESULT_W-1:0]  result_value,
  output logic                                 status
);
  import vc3_pkg::*;

  // Captured item.
  cmd_code_t                   item_cmd;
  logic [COORD_W-1:0]          item_x, item_y, item_z;
  logic [TAP_W-1:0]            item_tap;
  logic signed [SAMPLE_W-1:0]  item_sample;

  logic [SIZE_W-1:0] eff_x, eff_y, eff_z;

  logic signed [SAMPLE_W-1:0] kernel [KTAPS];

  // Tap sequencing.
  logic [KT_W-1:0]   tap_cnt;
  logic [KOFF_W-1:0] off_x, off_y, off_z;

  // Neighbor of the current tap.
  logic [NB_W-1:0]   nb_x, nb_y, nb_z;
  logic              nb_out;

  logic [VOX_AW-1:0]   ram_addr;
  logic                ram_en;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Pipeline stages.
  logic                       v1, pad1, v2;
  logic signed [SAMPLE_W-1:0] coef1;
  logic signed [SAMPLE_W-1:0] opnd;
  logic signed [PROD_W-1:0]   prod2;
  logic signed [RESULT_W-1:0] acc;

  assign eff_x = eff_size(size_x);
  assign eff_y = eff_size(size_y);
  assign eff_z = eff_size(size_z);

  always_ff @(posedge clk) begin
    if (cmd_in.capture) begin
      item_cmd    <= cmd_code_t'(cmd);
      item_x      <= coord_x;
      item_y      <= coord_y;
      item_z      <= coord_z;
      item_tap    <= tap_index;
      item_sample <= sample_value;
    end
  end

  always_comb begin
    st.cmd       = item_cmd;
    st.coord_err = (SIZE_W'(item_x) >= eff_x) || (SIZE_W'(item_y) >= eff_y) ||
                   (SIZE_W'(item_z) >= eff_z);
    st.tap_err   = (int'(item_tap) >= KTAPS);
    st.last_tap  = (tap_cnt == KT_W'(KTAPS - 1));
    st.busy      = v1 || v2;
    st.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KTAPS; i++) begin
        kernel[i] <= '0;
      end
    end else if (cmd_in.wr_kernel) begin
      kernel[KT_W'(item_tap)] <= item_sample;
    end
  end

  // Taps run with z innermost, matching the kernel index order.
  always_ff @(posedge clk) begin
    if (cmd_in.clear_acc) begin
      tap_cnt <= '0;
      off_x   <= '0;
      off_y   <= '0;
      off_z   <= '0;
    end else if (cmd_in.issue) begin
      tap_cnt <= tap_cnt + KT_W'(1);
      if (off_z == KOFF_W'(KSIDE - 1)) begin
        off_z <= '0;
        if (off_y == KOFF_W'(KSIDE - 1)) begin
          off_y <= '0;
          off_x <= off_x + KOFF_W'(1);
        end else begin
          off_y <= off_y + KOFF_W'(1);
        end
      end else begin
        off_z <= off_z + KOFF_W'(1);
      end
    end
  end

  // A neighbor below zero wraps to a large unsigned value, so one compare per axis
  // covers both sides of the volume.
  always_comb begin
    nb_x   = NB_W'(item_x) + NB_W'(off_x) - NB_W'(KERNEL_RADIUS);
    nb_y   = NB_W'(item_y) + NB_W'(off_y) - NB_W'(KERNEL_RADIUS);
    nb_z   = NB_W'(item_z) + NB_W'(off_z) - NB_W'(KERNEL_RADIUS);
    nb_out = (nb_x >= NB_W'(eff_x)) || (nb_y >= NB_W'(eff_y)) || (nb_z >= NB_W'(eff_z));
  end

  always_comb begin
    if (cmd_in.issue) begin
      ram_addr = {nb_x[CW-1:0], nb_y[CW-1:0], nb_z[CW-1:0]};
    end else begin
      ram_addr = {item_x[CW-1:0], item_y[CW-1:0], item_z[CW-1:0]};
    end
    ram_en = cmd_in.issue || cmd_in.wr_voxel;
  end

  vc3_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(VOXELS)
  ) u_voxel_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (cmd_in.wr_voxel),
    .addr (ram_addr),
    .wdata(item_sample),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd_in.issue;
      v2 <= v1;
    end
  end

  assign opnd = pad1 ? pad_level : $signed(ram_rdata);

  always_ff @(posedge clk) begin
    pad1  <= nb_out;
    coef1 <= kernel[tap_cnt];
    prod2 <= coef1 * opnd;
    if (cmd_in.clear_acc) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(RESULT_W - PROD_W){prod2[PROD_W-1]}}, prod2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_in.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.finish) begin
      result_value <= acc;
      status       <= cmd_in.fin_status;
    end
  end

endmodule

@@ rtl/volume_convolution_3x3x3.sv @@
// 3x3x3 volume convolution: a kernel load or voxel write item passes through decode and result
// hand-off, and the next item is taken only after the previous item's result is loaded.
// A compute item also runs tap issue and pipeline drain before its result, with one
// multiply-accumulate per kernel tap through the single voxel RAM port.
// Reset clears the controller, the kernel to zero and the registers to 16, 16, 16 and 0;
// the voxel volume is not cleared and must be written before it is read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module volume_convolution_3x3x3 (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vc3_pkg::PADDR_W-1:0]          paddr,
  input  logic [vc3_pkg::PDATA_W-1:0]          pwdata,
  output logic [vc3_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [vc3_pkg::CMD_W-1:0]            cmd,
  input  logic [vc3_pkg::COORD_W-1:0]          coord_x,
  input  logic [vc3_pkg::COORD_W-1:0]          coord_y,
  input  logic [vc3_pkg::COORD_W-1:0]          coord_z,
  input  logic [vc3_pkg::TAP_W-1:0]            tap_index,
  input  logic signed [vc3_pkg::SAMPLE_W-1:0]  sample_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [vc3_pkg::RESULT_W-1:0]  result_value,
  output logic                                 status
);
  import vc3_pkg::*;

  logic [SIZE_W-1:0]          size_x, size_y, size_z;
  logic signed [SAMPLE_W-1:0] pad_level;
  reg_idx_t                   reg_sel;

  ctrl_cmd_t  ctl;
  dp_status_t dst;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= SIZE_W'(DIM_MAX);
      size_y    <= SIZE_W'(DIM_MAX);
      size_z    <= SIZE_W'(DIM_MAX);
      pad_level <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SIZE_X:    size_x    <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:    size_y    <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:    size_z    <= pwdata[SIZE_W-1:0];
        REG_PAD_LEVEL: pad_level <= pwdata[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SIZE_X:    prdata = PDATA_W'(size_x);
      REG_SIZE_Y:    prdata = PDATA_W'(size_y);
      REG_SIZE_Z:    prdata = PDATA_W'(size_z);
      REG_PAD_LEVEL: prdata = {{(PDATA_W - SAMPLE_W){1'b0}}, pad_level};
      default:       prdata = '0;
    endcase
  end

  vc3_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (dst),
    .cmd     (ctl)
  );

  vc3_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd_in      (ctl),
    .st          (dst),
    .cmd         (cmd),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .tap_index   (tap_index),
    .sample_value(sample_value),
    .size_x      (size_x),
    .size_y      (size_y),
    .size_z      (size_z),
    .pad_level   (pad_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_value(result_value),
    .status      (status)
  );

  // A result is only loaded when the output register can take it.
  `ASSERT_IMPLY(a_finish_free, clk, rst, ctl.finish, dst.out_free, "result loaded over pending item")
  // Tap reads and voxel writes share the RAM port and never coincide.
  `ASSERT_NEVER(a_ram_port, clk, rst, ctl.issue && ctl.wr_voxel, "RAM read and write together")
  // Issue stops right after the last tap.
  `ASSERT_NEXT(a_last_tap, clk, rst, ctl.issue && dst.last_tap, !ctl.issue, "tap issued past the end")
  // The pipeline is empty whenever a new item is accepted.
  `ASSERT_IMPLY(a_accept_empty, clk, rst, in_valid && !in_stall, !dst.busy, "item accepted while busy")

endmodule
